### rtl/dictionary_index_bit_packer_macros.svh
// Assertion macros for the dictionary index bit packer.
// Included by the top level; depends on nothing else.
`ifndef DICTIONARY_INDEX_BIT_PACKER_MACROS_SVH
`define DICTIONARY_INDEX_BIT_PACKER_MACROS_SVH

`ifndef SYNTHESIS
`define DIBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dibp assertion failed");
`define DIBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dibp assertion failed");
`else
`define DIBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DIBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/dibp_pkg.sv
// Shared types, codes and helper functions of the dictionary index bit packer.
// Used by the channel interfaces and the top level; depends on nothing.
package dibp_pkg;

  localparam int unsigned ALPHABET_SIZE = 256;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_LOAD = 2'd0;
  localparam kind_t KIND_DATA = 2'd1;
  localparam kind_t KIND_END  = 2'd2;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_DICT_SIZE    = 1'b0;
  localparam cfg_idx_t CFG_SYMBOL_COUNT = 1'b1;

  localparam logic [8:0] DICT_SIZE_RESET = 9'd256;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_value;
    logic [7:0] entry_position;
  } item_t;

  // Code width: max(1, ceil(log2(size))) for a clamped size of at most 256.
  function automatic logic [3:0] code_width(input logic [8:0] eff);
    logic [3:0] w;
    w = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if ((9'd1 << i) < eff) begin
        w = 4'(i + 1);
      end
    end
    if (w == 4'd0) begin
      w = 4'd1;
    end
    return w;
  endfunction

  // Padding count sent ahead of the stream; only the low three bits of the
  // symbol count matter modulo eight.
  function automatic logic [2:0] header_pad(input logic [3:0] w, input logic [2:0] sc);
    logic [6:0] prod;
    logic [2:0] total;
    prod  = 7'(w) * 7'(sc);
    total = 3'(prod + 7'd3);
    return 3'(3'd0 - total);
  endfunction

endpackage

### rtl/dibp_in_if.sv
// Input channel of the dictionary index bit packer: valid, ready and one item.
// Depends on dibp_pkg.
interface dibp_in_if
  import dibp_pkg::*;
;
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] byte_value;
  logic [7:0] entry_position;

  modport source (output valid, kind, byte_value, entry_position, input ready);
  modport sink (input valid, kind, byte_value, entry_position, output ready);
endinterface

### rtl/dibp_out_if.sv
// Result channel of the dictionary index bit packer: valid, ready and one result.
// Depends on dibp_pkg.
interface dibp_out_if
  import dibp_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, out_byte, byte_valid, last, input ready);
  modport sink (input valid, out_byte, byte_valid, last, output ready);
endinterface

### rtl/dictionary_index_bit_packer.sv
// Dictionary index bit packer: replaces each data byte by its dictionary index
// and packs the codes MSB first into bytes. Depends on dibp_pkg, the two
// channel interfaces and the assertion macro header.
//
// One beat is taken every cycle while results are being taken. A beat first
// reads the 256-entry reverse map (a synchronous RAM with per-entry valid
// flops, so reset needs no clearing pass), then updates the map or the bit
// buffer and loads the output register. A map write followed at once by a
// read of the same entry is served by forwarding. A data beat gives a result
// only when a full byte is ready; an end beat always gives one, flagged last,
// and returns the packer to the header state.
`include "dictionary_index_bit_packer_macros.svh"

module dictionary_index_bit_packer
  import dibp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_wdata,
  dibp_in_if.sink     in_ch,
  dibp_out_if.source  out_ch
);

  logic [8:0]  dict_size_r;
  logic [31:0] symbol_count_r;

  logic [7:0]   map_mem [256];
  logic [7:0]   map_rd_r;
  logic [255:0] map_vld_r;

  item_t s1_r;
  logic  s1_v_r;
  logic  fwd_hit_r;
  logic [7:0] fwd_idx_r;

  logic [15:0] buf_r, buf_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic        hdr_r, hdr_nxt;

  logic       out_v_r;
  logic [7:0] out_byte_r;
  logic       out_bv_r;
  logic       out_last_r;

  logic       in_acc, s1_go, map_we;
  logic [8:0] eff;
  logic [3:0] w;
  logic [2:0] pad;
  logic       e_vld, hit, hdr_push, emit;
  logic [7:0] e_idx, res_byte;
  logic       res_bv, res_last;
  logic [15:0] buf1, buf2;
  logic [3:0]  fill1, fill2, sh, padn;

  assign eff = (dict_size_r > 9'(ALPHABET_SIZE)) ? 9'(ALPHABET_SIZE) : dict_size_r;
  assign w   = code_width(eff);
  assign pad = header_pad(w, symbol_count_r[2:0]);

  assign s1_go       = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_go;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign e_vld  = map_vld_r[s1_r.byte_value];
  assign e_idx  = fwd_hit_r ? fwd_idx_r : map_rd_r;
  assign map_we = s1_go && (s1_r.kind == KIND_LOAD) &&
                  (!e_vld || (s1_r.entry_position < e_idx));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dict_size_r    <= DICT_SIZE_RESET;
      symbol_count_r <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DICT_SIZE:    dict_size_r    <= cfg_wdata[8:0];
        CFG_SYMBOL_COUNT: symbol_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[s1_r.byte_value] <= s1_r.entry_position;
    end
    if (in_acc) begin
      map_rd_r <= map_mem[in_ch.byte_value];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r <= '0;
      fwd_hit_r <= 1'b0;
      s1_v_r    <= 1'b0;
    end else begin
      if (map_we) begin
        map_vld_r[s1_r.byte_value] <= 1'b1;
      end
      if (in_acc) begin
        fwd_hit_r <= map_we && (in_ch.byte_value == s1_r.byte_value);
      end else if (s1_go) begin
        fwd_hit_r <= 1'b0;
      end
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r      <= '{kind: in_ch.kind, byte_value: in_ch.byte_value,
                     entry_position: in_ch.entry_position};
      fwd_idx_r <= s1_r.entry_position;
    end
  end

  always_comb begin
    hdr_push = !hdr_r && ((s1_r.kind == KIND_DATA) || (s1_r.kind == KIND_END));
    buf1     = hdr_push ? {13'd0, pad} : buf_r;
    fill1    = hdr_push ? 4'd3 : {1'b0, fill_r};
    hit      = e_vld && ({1'b0, e_idx} < eff);
    buf2     = hit ? ((buf1 << w) | {8'd0, e_idx}) : buf1;
    fill2    = hit ? (fill1 + w) : fill1;
    sh       = fill2 - 4'd8;
    padn     = 4'd8 - fill1;
    buf_nxt  = buf_r;
    fill_nxt = fill_r;
    hdr_nxt  = hdr_r;
    emit     = 1'b0;
    res_byte = 8'd0;
    res_bv   = 1'b0;
    res_last = 1'b0;
    case (s1_r.kind)
      KIND_DATA: begin
        hdr_nxt = 1'b1;
        if (fill2 >= 4'd8) begin
          emit     = 1'b1;
          res_byte = 8'(buf2 >> sh);
          res_bv   = 1'b1;
          buf_nxt  = buf2 & ((16'd1 << sh) - 16'd1);
          fill_nxt = 3'(sh);
        end else begin
          buf_nxt  = buf2;
          fill_nxt = 3'(fill2);
        end
      end
      KIND_END: begin
        emit     = 1'b1;
        res_last = 1'b1;
        if (fill1 != 4'd0) begin
          res_byte = 8'((buf1 << padn) | (16'h00FF >> fill1));
          res_bv   = 1'b1;
        end
        buf_nxt  = 16'd0;
        fill_nxt = 3'd0;
        hdr_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= 16'd0;
      fill_r  <= 3'd0;
      hdr_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_go) begin
        buf_r  <= buf_nxt;
        fill_r <= fill_nxt;
        hdr_r  <= hdr_nxt;
      end
      if (s1_go && emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_byte_r <= res_byte;
      out_bv_r   <= res_bv;
      out_last_r <= res_last;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.byte_valid = out_bv_r;
  assign out_ch.last       = out_last_r;

  `DIBP_ASSERT_NOW(a_fill_clear_before_header, clk, rst_n, !hdr_r, (fill_r == 3'd0) && (buf_r == 16'd0))
  `DIBP_ASSERT_NEXT(a_end_resets_packer, clk, rst_n, s1_go && (s1_r.kind == KIND_END), !hdr_r && (fill_r == 3'd0) && out_v_r && out_last_r)
  `DIBP_ASSERT_NOW(a_forward_needs_item, clk, rst_n, fwd_hit_r, s1_v_r)

endmodule
